@@ hdl/cbelf_pkg.sv @@
`timescale 1ns / 1ps

package cbelf_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [15:0] end_line;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [9:0] {
		PH_SKIP     = 10'b00_0000_0001,
		PH_SEARCH   = 10'b00_0000_0010,
		PH_BODY     = 10'b00_0000_0100,
		PH_STR      = 10'b00_0000_1000,
		PH_CHR      = 10'b00_0001_0000,
		PH_SLASH    = 10'b00_0010_0000,
		PH_BLK      = 10'b00_0100_0000,
		PH_BLKSTAR  = 10'b00_1000_0000,
		PH_LINECMT  = 10'b01_0000_0000,
		PH_DONE     = 10'b10_0000_0000
	} phase_t;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_EARLY = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_DQ    = 8'd34;
	localparam logic [7:0] CH_SQ    = 8'd39;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_OPEN  = 8'd123;
	localparam logic [7:0] CH_CLOSE = 8'd125;

	localparam logic [15:0] START_LINE_RST = 16'd1;

endpackage

@@ hdl/c_block_end_line_finder_top.sv @@
`timescale 1ns / 1ps
// Pipeline: a byte is registered in item_s1 on acceptance, and its result, if
// any, is registered in out_q when that byte is processed.
// Throughput: one byte per cycle while no result is held by out_stall; the
// state registers (phase, depth, line count) are updated once per byte.
// Reset: arst_n clears the pipeline, the scan state and sets start_line to 1.

module c_block_end_line_finder_top
	import cbelf_pkg::*;
#(
	parameter int LINE_BITS  = 16,
	parameter int DEPTH_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	localparam int CMP_W = (LINE_BITS > 16) ? LINE_BITS : 16;
	localparam logic [LINE_BITS-1:0]  LINE_MAX  = {LINE_BITS{1'b1}};
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

	logic [15:0]           start_line_q;
	logic                  valid_s1;
	in_item_t              item_s1;
	phase_t                phase_q, phase_n, phase_eff;
	logic [LINE_BITS-1:0]  line_q, line_n, line_inc, res_line;
	logic [DEPTH_BITS-1:0] depth_q, depth_n, depth_dec;
	logic                  advance, emit, do_body;
	logic [1:0]            res_status;
	logic [CMP_W-1:0]      line_ext, start_ext;
	logic [7:0]            c;
	logic                  out_valid_q;
	out_item_t             out_q;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign c         = item_s1.char_code;
	assign line_inc  = (line_q == LINE_MAX) ? line_q : line_q + LINE_BITS'(1);
	assign depth_dec = (depth_q != '0) ? depth_q - DEPTH_BITS'(1) : depth_q;
	assign line_ext  = CMP_W'(line_q);
	assign start_ext = CMP_W'(start_line_q);

	always_comb begin
		phase_n    = phase_q;
		line_n     = line_q;
		depth_n    = depth_q;
		emit       = 1'b0;
		res_line   = '0;
		res_status = ST_FOUND;
		do_body    = 1'b0;
		phase_eff  = phase_q;
		if (item_s1.end_of_file) begin
			phase_n    = PH_SKIP;
			line_n     = LINE_BITS'(1);
			depth_n    = '0;
			emit       = (phase_q != PH_DONE);
			res_status = ST_EARLY;
		end else begin
			if (phase_q == PH_SKIP && line_ext == start_ext) begin
				phase_eff = PH_SEARCH;
			end
			phase_n = phase_eff;
			unique case (phase_eff)
				PH_SKIP: begin
					if (c == CH_NL) line_n = line_inc;
				end
				PH_SEARCH: begin
					if (c == CH_NL) begin
						line_n = line_inc;
					end else if (c == CH_OPEN) begin
						depth_n = DEPTH_BITS'(1);
						phase_n = PH_BODY;
					end
				end
				PH_BODY: do_body = 1'b1;
				PH_STR: begin
					if (c == CH_NL) line_n = line_inc;
					else if (c == CH_DQ) phase_n = PH_BODY;
				end
				PH_CHR: begin
					if (c == CH_NL) line_n = line_inc;
					else if (c == CH_SQ) phase_n = PH_BODY;
				end
				PH_SLASH: begin
					if (c == CH_NL) line_n = line_inc;
					else if (c == CH_SP) phase_n = PH_SLASH;
					else if (c == CH_STAR) phase_n = PH_BLK;
					else if (c == CH_SLASH) phase_n = PH_LINECMT;
					else do_body = 1'b1;
				end
				PH_BLK: begin
					if (c == CH_NL) line_n = line_inc;
					else if (c == CH_STAR) phase_n = PH_BLKSTAR;
				end
				PH_BLKSTAR: begin
					if (c == CH_SLASH) begin
						phase_n = PH_BODY;
					end else if (c != CH_STAR) begin
						if (c == CH_NL) line_n = line_inc;
						phase_n = PH_BLK;
					end
				end
				PH_LINECMT: begin
					if (c == CH_NL) begin
						line_n  = line_inc;
						phase_n = PH_BODY;
					end
				end
				PH_DONE: phase_n = PH_DONE;
				default: phase_n = PH_SKIP;
			endcase
			if (do_body) begin
				phase_n = PH_BODY;
				case (c)
					CH_DQ:    phase_n = PH_STR;
					CH_SQ:    phase_n = PH_CHR;
					CH_SLASH: phase_n = PH_SLASH;
					CH_NL:    line_n = line_inc;
					CH_OPEN: begin
						if (depth_q == DEPTH_MAX) begin
							phase_n    = PH_DONE;
							emit       = 1'b1;
							res_line   = line_q;
							res_status = ST_OVF;
						end else begin
							depth_n = depth_q + DEPTH_BITS'(1);
						end
					end
					CH_CLOSE: begin
						depth_n = depth_dec;
						if (depth_dec == '0) begin
							phase_n    = PH_DONE;
							emit       = 1'b1;
							res_line   = line_q;
							res_status = ST_FOUND;
						end
					end
					default: phase_n = PH_BODY;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line_q <= START_LINE_RST;
		end else if (cfg_wr_en) begin
			start_line_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			line_q  <= LINE_BITS'(1);
			depth_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			line_q  <= line_n;
			depth_q <= depth_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q.end_line <= (CMP_W'(res_line) > CMP_W'(16'hFFFF)) ?
				16'hFFFF : 16'(res_line);
			out_q.status   <= res_status;
		end
	end

endmodule

@@ hdl/cbelf_checker.sv @@
`timescale 1ns / 1ps

module cbelf_checker
	import cbelf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input in_item_t    in_data,
	input logic        out_valid,
	input logic        out_stall,
	input out_item_t   out_data
);

	// hold a stalled byte transaction
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled byte transaction changed");

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result transaction changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_FOUND || out_data.status == ST_EARLY ||
			out_data.status == ST_OVF))
		else $error("undefined status code");

	a_early_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EARLY |-> out_data.end_line == 16'd0)
		else $error("early end carries a line number");

	// stall input only while a result is blocked downstream
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

endmodule

bind c_block_end_line_finder_top cbelf_checker u_cbelf_checker (.*);
